// ===== hdl/shrq_pkg.sv =====
package shrq_pkg;

	// Operation codes carried in the input beat
	typedef enum logic [2:0] {
		OP_INSERT       = 3'd0,
		OP_READ_FIRST   = 3'd1,
		OP_READ_NTH     = 3'd2,
		OP_READ_LAST    = 3'd3,
		OP_REMOVE_NTH   = 3'd4,
		OP_REMOVE_FIRST = 3'd5,
		OP_SWAP         = 3'd6,
		OP_FLUSH        = 3'd7
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BOUNDS = 2'd3
	} status_t;

	// Controller states, one-hot
	typedef enum logic [9:0] {
		S_CLEAR    = 10'b00_0000_0001,
		S_IDLE     = 10'b00_0000_0010,
		S_DECODE   = 10'b00_0000_0100,
		S_READ     = 10'b00_0000_1000,
		S_SWAP_B   = 10'b00_0001_0000,
		S_SWAP_WR  = 10'b00_0010_0000,
		S_SHIFT_RD = 10'b00_0100_0000,
		S_SHIFT_WR = 10'b00_1000_0000,
		S_PARK     = 10'b01_0000_0000,
		S_RESP     = 10'b10_0000_0000
	} state_t;

	// Field widths of the stream beats
	localparam int OP_W     = 3;
	localparam int POS_W    = 4;
	localparam int HANDLE_W = 4;
	localparam int STATUS_W = 2;
	localparam int OCC_W    = 5;

	// Commands from controller to datapath
	typedef struct packed {
		logic clear_wr;   // write one entry of the clearing pass
		logic load_in;    // capture the input beat
		logic decode;     // check, issue first read, apply head-only ops
		logic read_done;  // consume first read data
		logic swap_wr_a;  // write second value at first position
		logic swap_wr_b;  // write first value at second position
		logic shift_rd;   // read the entry behind the gap
		logic shift_wr;   // move it into the gap
		logic park;       // park the freed handle at the new tail
		logic out_load;   // load the output register
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		op_t  op;
		logic err;
		logic clear_last;
		logic first_more;
		logic next_more;
	} dp_sts_t;

endpackage

// ===== hdl/slot_handle_ring_queue_unit.sv =====
// One operation at a time, set by the controller sequencing one memory port.
// Each item passes decode and response; inserts and reads add one read step; swap adds
// a read step and two writes; remove nth adds a read step, one read and one write per shift, and a park write.
// Reset: head, tail and count clear at once, then a clearing pass loads each entry i
// with i while s_tready stays low.
module slot_handle_ring_queue_unit #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // operation[2:0], position_a[6:3], position_b[10:7]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // slot_handle[3:0], status[5:4], occupancy[10:6],
	                              // is_empty[11], is_full[12]
);

	shrq_pkg::dp_cmd_t              cmd;
	shrq_pkg::dp_sts_t              sts;
	logic [shrq_pkg::HANDLE_W-1:0]  slot_handle;
	logic [shrq_pkg::STATUS_W-1:0]  status;
	logic [shrq_pkg::OCC_W-1:0]     occupancy;
	logic                           is_empty;
	logic                           is_full;

	shrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	shrq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_operation  (s_tdata[2:0]),
		.in_position_a (s_tdata[6:3]),
		.in_position_b (s_tdata[10:7]),
		.slot_handle   (slot_handle),
		.status        (status),
		.occupancy     (occupancy),
		.is_empty      (is_empty),
		.is_full       (is_full)
	);

	// Pack the result beat
	assign m_tdata = {3'b000, is_full, is_empty, occupancy, status, slot_handle};

	// One item in flight: no new beat right after an accepted one
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted while an item is in flight");

	// Empty flag agrees with occupancy
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[11] == (m_tdata[10:6] == 5'd0)))
		else $error("is_empty disagrees with occupancy");

	// An error result carries no handle
	a_err_handle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5:4] != 2'd0 |-> m_tdata[3:0] == 4'd0)
		else $error("error result with nonzero handle");

	// A full queue cannot be reported empty
	a_full_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[11] && m_tdata[12]))
		else $error("queue reported both full and empty");

endmodule

// ===== hdl/shrq_ram.sv =====
module shrq_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/shrq_ctrl.sv =====
module shrq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  shrq_pkg::dp_sts_t sts,
	output shrq_pkg::dp_cmd_t cmd
);

	shrq_pkg::state_t state_q;
	shrq_pkg::state_t state_nxt;
	logic             out_valid_q;

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			shrq_pkg::S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) begin
					state_nxt = shrq_pkg::S_IDLE;
				end
			end
			shrq_pkg::S_IDLE: begin
				cmd.load_in = s_tvalid;
				if (s_tvalid) begin
					state_nxt = shrq_pkg::S_DECODE;
				end
			end
			shrq_pkg::S_DECODE: begin
				cmd.decode = 1'b1;
				if (sts.err || sts.op == shrq_pkg::OP_REMOVE_FIRST ||
						sts.op == shrq_pkg::OP_FLUSH) begin
					state_nxt = shrq_pkg::S_RESP;
				end else begin
					state_nxt = shrq_pkg::S_READ;
				end
			end
			shrq_pkg::S_READ: begin
				cmd.read_done = 1'b1;
				if (sts.op == shrq_pkg::OP_SWAP) begin
					state_nxt = shrq_pkg::S_SWAP_B;
				end else if (sts.op == shrq_pkg::OP_REMOVE_NTH) begin
					state_nxt = sts.first_more ? shrq_pkg::S_SHIFT_RD : shrq_pkg::S_PARK;
				end else begin
					state_nxt = shrq_pkg::S_RESP;
				end
			end
			shrq_pkg::S_SWAP_B: begin
				cmd.swap_wr_a = 1'b1;
				state_nxt     = shrq_pkg::S_SWAP_WR;
			end
			shrq_pkg::S_SWAP_WR: begin
				cmd.swap_wr_b = 1'b1;
				state_nxt     = shrq_pkg::S_RESP;
			end
			shrq_pkg::S_SHIFT_RD: begin
				cmd.shift_rd = 1'b1;
				state_nxt    = shrq_pkg::S_SHIFT_WR;
			end
			shrq_pkg::S_SHIFT_WR: begin
				cmd.shift_wr = 1'b1;
				state_nxt    = sts.next_more ? shrq_pkg::S_SHIFT_RD : shrq_pkg::S_PARK;
			end
			shrq_pkg::S_PARK: begin
				cmd.park  = 1'b1;
				state_nxt = shrq_pkg::S_RESP;
			end
			shrq_pkg::S_RESP: begin
				// Hand the result over once the output register is free
				cmd.out_load = !out_valid_q || m_tready;
				if (!out_valid_q || m_tready) begin
					state_nxt = shrq_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = shrq_pkg::S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shrq_pkg::S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign s_tready = (state_q == shrq_pkg::S_IDLE);
	assign m_tvalid = out_valid_q;

endmodule

// ===== hdl/shrq_dp.sv =====
module shrq_dp #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  shrq_pkg::dp_cmd_t             cmd,
	output shrq_pkg::dp_sts_t             sts,
	input  logic [shrq_pkg::OP_W-1:0]     in_operation,
	input  logic [shrq_pkg::POS_W-1:0]    in_position_a,
	input  logic [shrq_pkg::POS_W-1:0]    in_position_b,
	output logic [shrq_pkg::HANDLE_W-1:0] slot_handle,
	output logic [shrq_pkg::STATUS_W-1:0] status,
	output logic [shrq_pkg::OCC_W-1:0]    occupancy,
	output logic                          is_empty,
	output logic                          is_full
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int CW1 = CW + 1;
	localparam int MW  = AW + shrq_pkg::POS_W + 1;
	localparam int XW  = CW + shrq_pkg::POS_W;
	localparam logic [AW:0]    DEPTH_S = (AW + 1)'(DEPTH);
	localparam logic [MW-1:0]  DEPTH_M = MW'(DEPTH);
	localparam logic [AW-1:0]  LAST_IX = AW'(DEPTH - 1);
	localparam logic [CW-1:0]  DEPTH_C = CW'(DEPTH);

	// Ring index of an offset from the head (both below DEPTH)
	function automatic logic [AW-1:0] ring_at(input logic [AW-1:0] head,
			input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, head} + {1'b0, off};
		if (sum >= DEPTH_S) begin
			sum = sum - DEPTH_S;
		end
		return sum[AW-1:0];
	endfunction

	// Position reduced modulo DEPTH by repeated subtraction
	function automatic logic [AW-1:0] pos_mod(input logic [shrq_pkg::POS_W-1:0] p);
		logic [MW-1:0] r;
		r = MW'(p);
		for (int k = 0; k < 8; k++) begin
			if (r >= DEPTH_M) begin
				r = r - DEPTH_M;
			end
		end
		return r[AW-1:0];
	endfunction

	// Ring entry narrowed or widened to the handle field
	function automatic logic [shrq_pkg::HANDLE_W-1:0] to_handle(input logic [AW-1:0] v);
		logic [AW+shrq_pkg::HANDLE_W-1:0] ext;
		ext = {{shrq_pkg::HANDLE_W{1'b0}}, v};
		return ext[shrq_pkg::HANDLE_W-1:0];
	endfunction

	logic [AW-1:0]             head_q, tail_q, clr_q;
	logic [CW-1:0]             count_q;
	shrq_pkg::op_t             op_q;
	logic [shrq_pkg::POS_W-1:0] pa_q;
	logic [AW-1:0]             pam_q, pbm_q, idx_q, hold_q;
	logic [shrq_pkg::HANDLE_W-1:0] handle_q;
	shrq_pkg::status_t         status_q;

	logic [shrq_pkg::HANDLE_W-1:0] out_handle_q;
	logic [shrq_pkg::STATUS_W-1:0] out_status_q;
	logic [shrq_pkg::OCC_W-1:0]    out_occ_q;
	logic                          out_empty_q, out_full_q;

	logic [AW-1:0]     tail_m1, head_p1, tail_p1, cnt_m1_ix;
	logic [CW-1:0]     cnt_m1;
	logic              q_full, q_empty, pa_oob;
	shrq_pkg::status_t chk;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_wdata, ram_raddr, ram_rdata;
	logic [CW+shrq_pkg::OCC_W-1:0] occ_ext;

	// Pointer arithmetic
	assign tail_m1   = (tail_q == '0) ? LAST_IX : tail_q - AW'(1);
	assign tail_p1   = (tail_q == LAST_IX) ? '0 : tail_q + AW'(1);
	assign head_p1   = (head_q == LAST_IX) ? '0 : head_q + AW'(1);
	assign cnt_m1    = count_q - CW'(1);
	assign cnt_m1_ix = cnt_m1[AW-1:0];

	// Error checks of the held operation
	assign q_full  = (count_q == DEPTH_C);
	assign q_empty = (count_q == '0);
	assign pa_oob  = (XW'(pa_q) >= XW'(count_q));

	always_comb begin
		chk = shrq_pkg::ST_OK;
		case (op_q)
			shrq_pkg::OP_INSERT: begin
				if (q_full) chk = shrq_pkg::ST_FULL;
			end
			shrq_pkg::OP_READ_FIRST, shrq_pkg::OP_READ_LAST,
			shrq_pkg::OP_REMOVE_FIRST: begin
				if (q_empty) chk = shrq_pkg::ST_EMPTY;
			end
			shrq_pkg::OP_READ_NTH, shrq_pkg::OP_REMOVE_NTH: begin
				if (pa_oob) chk = shrq_pkg::ST_BOUNDS;
			end
			default: begin
				chk = shrq_pkg::ST_OK;
			end
		endcase
	end

	assign sts.op         = op_q;
	assign sts.err        = (chk != shrq_pkg::ST_OK);
	assign sts.clear_last = (clr_q == LAST_IX);
	assign sts.first_more = (CW1'(pam_q) + CW1'(1)) < CW1'(count_q);
	assign sts.next_more  = (CW1'(idx_q) + CW1'(2)) < CW1'(count_q);

	// Memory read address
	always_comb begin
		ram_raddr = head_q;
		if (cmd.decode) begin
			case (op_q)
				shrq_pkg::OP_INSERT:     ram_raddr = tail_q;
				shrq_pkg::OP_READ_FIRST: ram_raddr = head_q;
				shrq_pkg::OP_READ_LAST:  ram_raddr = tail_m1;
				default:                 ram_raddr = ring_at(head_q, pam_q);
			endcase
		end else if (cmd.read_done) begin
			ram_raddr = ring_at(head_q, pbm_q);
		end else if (cmd.shift_rd) begin
			ram_raddr = ring_at(head_q, idx_q + AW'(1));
		end
	end

	// Memory write port
	always_comb begin
		ram_we    = cmd.clear_wr | cmd.swap_wr_a | cmd.swap_wr_b | cmd.shift_wr | cmd.park;
		ram_waddr = clr_q;
		ram_wdata = clr_q;
		if (cmd.swap_wr_a) begin
			ram_waddr = ring_at(head_q, pam_q);
			ram_wdata = ram_rdata;
		end else if (cmd.swap_wr_b) begin
			ram_waddr = ring_at(head_q, pbm_q);
			ram_wdata = hold_q;
		end else if (cmd.shift_wr) begin
			ram_waddr = ring_at(head_q, idx_q);
			ram_wdata = ram_rdata;
		end else if (cmd.park) begin
			ram_waddr = ring_at(head_q, cnt_m1_ix);
			ram_wdata = hold_q;
		end
	end

	shrq_ram #(
		.WIDTH (AW),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Head, tail, count and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.clear_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.decode && chk == shrq_pkg::ST_OK) begin
				if (op_q == shrq_pkg::OP_REMOVE_FIRST) begin
					head_q  <= head_p1;
					count_q <= cnt_m1;
				end else if (op_q == shrq_pkg::OP_FLUSH) begin
					head_q  <= tail_q;
					count_q <= '0;
				end
			end
			if (cmd.read_done && op_q == shrq_pkg::OP_INSERT) begin
				tail_q  <= tail_p1;
				count_q <= count_q + CW'(1);
			end
			if (cmd.park) begin
				tail_q  <= tail_m1;
				count_q <= cnt_m1;
			end
		end
	end

	// Held operation and working values
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q  <= shrq_pkg::op_t'(in_operation);
			pa_q  <= in_position_a;
			pam_q <= pos_mod(in_position_a);
			pbm_q <= pos_mod(in_position_b);
		end
		if (cmd.decode) begin
			status_q <= chk;
			handle_q <= '0;
		end
		if (cmd.read_done) begin
			hold_q <= ram_rdata;
			idx_q  <= pam_q;
			if (op_q != shrq_pkg::OP_SWAP && op_q != shrq_pkg::OP_REMOVE_NTH) begin
				handle_q <= to_handle(ram_rdata);
			end
		end
		if (cmd.shift_wr) begin
			idx_q <= idx_q + AW'(1);
		end
	end

	// Output register
	assign occ_ext = {{shrq_pkg::OCC_W{1'b0}}, count_q};

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_handle_q <= handle_q;
			out_status_q <= status_q;
			out_occ_q    <= occ_ext[shrq_pkg::OCC_W-1:0];
			out_empty_q  <= q_empty;
			out_full_q   <= q_full;
		end
	end

	assign slot_handle = out_handle_q;
	assign status      = out_status_q;
	assign occupancy   = out_occ_q;
	assign is_empty    = out_empty_q;
	assign is_full     = out_full_q;

endmodule
